/* rtl/core/kas_pkg.sv */
package kas_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned TmoW    = 20;
  localparam int unsigned RetryW  = 8;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [TmoW-1:0]   ShortTimeoutRst      = 20'd3000;
  localparam logic [TmoW-1:0]   StepTimeoutRst       = 20'd5000;
  localparam logic [TmoW-1:0]   ReplyTimeoutRst      = 20'd50000;
  localparam logic [TmoW-1:0]   PlatformIdTimeoutRst = 20'd30000;
  localparam logic [TmoW-1:0]   TextTimeoutRst       = 20'd60000;
  localparam logic [RetryW-1:0] RetryLimitRst        = 8'd3;

  localparam logic [CfgIdxW-1:0] CFG_SHORT_TIMEOUT       = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_STEP_TIMEOUT        = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_REPLY_TIMEOUT       = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PLATFORM_ID_TIMEOUT = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TEXT_TIMEOUT        = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_RETRY_LIMIT         = 3'd5;

  localparam logic [2:0] REQ_PW_STATUS   = 3'd0;
  localparam logic [2:0] REQ_ID          = 3'd1;
  localparam logic [2:0] REQ_PUBLIC_KEY  = 3'd2;
  localparam logic [2:0] REQ_WRITE_PID   = 3'd3;
  localparam logic [2:0] REQ_WRITE_PKEY  = 3'd4;

  localparam logic [2:0] FAIL_PW_STATUS  = 3'd0;
  localparam logic [2:0] FAIL_ID         = 3'd1;
  localparam logic [2:0] FAIL_KEY        = 3'd2;
  localparam logic [2:0] FAIL_REPLY      = 3'd3;
  localparam logic [2:0] FAIL_PID_WAIT   = 3'd4;
  localparam logic [2:0] FAIL_ID_WRITE   = 3'd5;
  localparam logic [2:0] FAIL_KEY_WRITE  = 3'd6;
  localparam logic [2:0] FAIL_TEXT       = 3'd7;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_GET_PW      = 4'd1,
    PH_GET_ID      = 4'd2,
    PH_GET_KEY     = 4'd3,
    PH_SEND_PASS   = 4'd4,
    PH_AWAIT_REPLY = 4'd5,
    PH_WRITE_PID   = 4'd6,
    PH_AWAIT_PID   = 4'd7,
    PH_WRITE_PKEY  = 4'd8,
    PH_AWAIT_PKEY  = 4'd9,
    PH_SUCCESS     = 4'd10,
    PH_FAIL        = 4'd11,
    PH_AWAIT_TEXT  = 4'd12
  } phase_t;

  typedef struct packed {
    logic [TmoW-1:0]   short_timeout;
    logic [TmoW-1:0]   step_timeout;
    logic [TmoW-1:0]   reply_timeout;
    logic [TmoW-1:0]   platform_id_timeout;
    logic [TmoW-1:0]   text_timeout;
    logic [RetryW-1:0] retry_limit;
  } kas_cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] time_now;
    logic             cipher_text_present;
    logic             key_agree_notice;
    logic             password_status_got;
    logic             id_present;
    logic             key_present;
    logic             passthrough_ok;
    logic             platform_id_present;
    logic             platform_id_ack;
    logic             platform_key_ack;
  } kas_in_t;

  typedef struct packed {
    logic       request_valid;
    logic [2:0] request_kind;
    logic       send_flag_clear;
    logic       passthrough_start;
    logic       platform_id_release;
    logic       ack_valid;
    logic       ack_value;
    logic       failure_valid;
    logic [2:0] failure_step;
    logic [3:0] phase_now;
  } kas_result_t;

endpackage

/* rtl/core/kas_cfg.sv */
module kas_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [kas_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [kas_pkg::TmoW-1:0]       cfg_data,
  output kas_pkg::kas_cfg_t              cfg
);
  import kas_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_timeout       <= ShortTimeoutRst;
      cfg.step_timeout        <= StepTimeoutRst;
      cfg.reply_timeout       <= ReplyTimeoutRst;
      cfg.platform_id_timeout <= PlatformIdTimeoutRst;
      cfg.text_timeout        <= TextTimeoutRst;
      cfg.retry_limit         <= RetryLimitRst;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SHORT_TIMEOUT:       cfg.short_timeout       <= cfg_data;
        CFG_STEP_TIMEOUT:        cfg.step_timeout        <= cfg_data;
        CFG_REPLY_TIMEOUT:       cfg.reply_timeout       <= cfg_data;
        CFG_PLATFORM_ID_TIMEOUT: cfg.platform_id_timeout <= cfg_data;
        CFG_TEXT_TIMEOUT:        cfg.text_timeout        <= cfg_data;
        CFG_RETRY_LIMIT:         cfg.retry_limit         <= cfg_data[RetryW-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/kas_core.sv */
module kas_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step_en,
  input  kas_pkg::kas_in_t      req,
  input  kas_pkg::kas_cfg_t     cfg,
  output kas_pkg::kas_result_t  res
);
  import kas_pkg::*;

  phase_t              phase, phase_next;
  logic [TimeW-1:0]    timer_mark, timer_mark_next;
  logic [RetryW-1:0]   retry_count, retry_count_next;
  logic                passthrough_result, passthrough_result_next;

  logic [TimeW-1:0]    elapsed;
  logic [RetryW-1:0]   retry_inc;
  logic                retry_done;
  logic                exp_short, exp_step, exp_reply, exp_pid, exp_text;

  assign elapsed    = req.time_now - timer_mark;
  assign exp_short  = elapsed > {{(TimeW-TmoW){1'b0}}, cfg.short_timeout};
  assign exp_step   = elapsed > {{(TimeW-TmoW){1'b0}}, cfg.step_timeout};
  assign exp_reply  = elapsed > {{(TimeW-TmoW){1'b0}}, cfg.reply_timeout};
  assign exp_pid    = elapsed > {{(TimeW-TmoW){1'b0}}, cfg.platform_id_timeout};
  assign exp_text   = elapsed > {{(TimeW-TmoW){1'b0}}, cfg.text_timeout};
  assign retry_inc  = retry_count + 1'b1;
  assign retry_done = (retry_inc == cfg.retry_limit);

  always_comb begin
    phase_next              = phase;
    timer_mark_next         = timer_mark;
    retry_count_next        = retry_count;
    passthrough_result_next = passthrough_result;
    res                     = '0;

    case (phase)
      PH_IDLE: begin
        if (!req.cipher_text_present || req.key_agree_notice) phase_next = PH_GET_PW;
      end
      PH_GET_PW: begin
        res.request_valid = 1'b1;
        res.request_kind  = REQ_PW_STATUS;
        phase_next        = PH_GET_ID;
        timer_mark_next   = req.time_now;
      end
      PH_GET_ID: begin
        if (req.password_status_got) begin
          res.request_valid = 1'b1;
          res.request_kind  = REQ_ID;
          phase_next        = PH_GET_KEY;
          timer_mark_next   = req.time_now;
        end else if (exp_short) begin
          res.failure_valid = 1'b1;
          res.failure_step  = FAIL_PW_STATUS;
          phase_next        = PH_IDLE;
          timer_mark_next   = '0;
        end
      end
      PH_GET_KEY: begin
        if (req.id_present) begin
          res.request_valid = 1'b1;
          res.request_kind  = REQ_PUBLIC_KEY;
          phase_next        = PH_SEND_PASS;
          timer_mark_next   = req.time_now;
        end else if (exp_short) begin
          res.failure_valid = 1'b1;
          res.failure_step  = FAIL_ID;
          phase_next        = PH_IDLE;
          timer_mark_next   = '0;
        end
      end
      PH_SEND_PASS: begin
        passthrough_result_next = 1'b0;
        if (req.key_present) begin
          res.send_flag_clear     = 1'b1;
          res.passthrough_start   = 1'b1;
          timer_mark_next         = req.time_now;
          passthrough_result_next = req.passthrough_ok;
          phase_next              = PH_AWAIT_REPLY;
        end else if (exp_step) begin
          res.failure_valid = 1'b1;
          res.failure_step  = FAIL_KEY;
          phase_next        = PH_IDLE;
          timer_mark_next   = '0;
        end
      end
      PH_AWAIT_REPLY: begin
        if (passthrough_result) begin
          phase_next      = PH_WRITE_PID;
          timer_mark_next = req.time_now;
        end else if (exp_reply) begin
          if (retry_done) begin
            retry_count_next  = '0;
            res.failure_valid = 1'b1;
            res.failure_step  = FAIL_REPLY;
            phase_next        = PH_IDLE;
            timer_mark_next   = '0;
          end else begin
            retry_count_next = retry_inc;
            phase_next       = PH_SEND_PASS;
          end
        end
      end
      PH_WRITE_PID: begin
        if (req.platform_id_present) begin
          res.request_valid = 1'b1;
          res.request_kind  = REQ_WRITE_PID;
          phase_next        = PH_AWAIT_PID;
          timer_mark_next   = req.time_now;
        end else if (exp_pid) begin
          res.failure_valid = 1'b1;
          res.failure_step  = FAIL_PID_WAIT;
          phase_next        = PH_IDLE;
          timer_mark_next   = '0;
        end
      end
      PH_AWAIT_PID: begin
        if (req.platform_id_ack) begin
          res.platform_id_release = 1'b1;
          phase_next              = PH_WRITE_PKEY;
        end else if (exp_step) begin
          if (retry_done) begin
            retry_count_next        = '0;
            res.platform_id_release = 1'b1;
            res.failure_valid       = 1'b1;
            res.failure_step        = FAIL_ID_WRITE;
            phase_next              = PH_IDLE;
            timer_mark_next         = '0;
          end else begin
            retry_count_next = retry_inc;
            phase_next       = PH_WRITE_PID;
          end
        end
      end
      PH_WRITE_PKEY: begin
        res.request_valid = 1'b1;
        res.request_kind  = REQ_WRITE_PKEY;
        phase_next        = PH_AWAIT_PKEY;
        timer_mark_next   = req.time_now;
      end
      PH_AWAIT_PKEY: begin
        if (req.platform_key_ack) begin
          phase_next = PH_SUCCESS;
        end else if (exp_step) begin
          if (retry_done) begin
            retry_count_next  = '0;
            res.failure_valid = 1'b1;
            res.failure_step  = FAIL_KEY_WRITE;
            phase_next        = PH_FAIL;
            timer_mark_next   = '0;
          end else begin
            retry_count_next = retry_inc;
            phase_next       = PH_WRITE_PKEY;
          end
        end
      end
      PH_SUCCESS: begin
        res.ack_valid   = 1'b1;
        phase_next      = PH_AWAIT_TEXT;
        timer_mark_next = req.time_now;
      end
      PH_FAIL: begin
        res.ack_valid = 1'b1;
        res.ack_value = 1'b1;
        phase_next    = PH_IDLE;
      end
      PH_AWAIT_TEXT: begin
        if (req.cipher_text_present) begin
          phase_next = PH_IDLE;
        end else if (exp_text) begin
          res.failure_valid = 1'b1;
          res.failure_step  = FAIL_TEXT;
          phase_next        = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    res.phase_now = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      timer_mark         <= '0;
      retry_count        <= '0;
      passthrough_result <= 1'b0;
    end else if (step_en) begin
      phase              <= phase_next;
      timer_mark         <= timer_mark_next;
      retry_count        <= retry_count_next;
      passthrough_result <= passthrough_result_next;
    end
  end

endmodule

/* rtl/core/key_agreement_sequencer.sv */
// A request accepted into the input register moves on into the result register,
// held back only while the result register is stalled.
// Throughput: one request per cycle when not stalled; the phase, timer mark and
// retry count update as a request moves from the input register to the result
// register. A stalled result holds the input register; new requests stall behind it.
// Synchronous active-high reset clears the pipeline, returns the sequencer to
// idle and loads the timeout and retry limit registers with their defaults.
module key_agreement_sequencer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [kas_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [kas_pkg::TmoW-1:0]     cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [kas_pkg::TimeW-1:0]    time_now,
  input  logic                         cipher_text_present,
  input  logic                         key_agree_notice,
  input  logic                         password_status_got,
  input  logic                         id_present,
  input  logic                         key_present,
  input  logic                         passthrough_ok,
  input  logic                         platform_id_present,
  input  logic                         platform_id_ack,
  input  logic                         platform_key_ack,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         request_valid,
  output logic [2:0]                   request_kind,
  output logic                         send_flag_clear,
  output logic                         passthrough_start,
  output logic                         platform_id_release,
  output logic                         ack_valid,
  output logic                         ack_value,
  output logic                         failure_valid,
  output logic [2:0]                   failure_step,
  output logic [3:0]                   phase_now
);
  import kas_pkg::*;

  kas_cfg_t    cfg;
  kas_in_t     in_req;
  logic        in_req_valid;
  kas_result_t step_res;
  kas_result_t out_res;
  logic        out_free;
  logic        advance;
  logic        accept;

  assign out_free = !out_valid || !out_stall;
  assign advance  = in_req_valid && out_free;
  assign in_stall = in_req_valid && !out_free;
  assign accept   = in_valid && !in_stall;

  kas_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kas_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .req     (in_req),
    .cfg     (cfg),
    .res     (step_res)
  );

  // hold the request until the result stage can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_req_valid <= 1'b0;
    end else if (accept) begin
      in_req_valid <= 1'b1;
    end else if (advance) begin
      in_req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_req.time_now            <= time_now;
      in_req.cipher_text_present <= cipher_text_present;
      in_req.key_agree_notice    <= key_agree_notice;
      in_req.password_status_got <= password_status_got;
      in_req.id_present          <= id_present;
      in_req.key_present         <= key_present;
      in_req.passthrough_ok      <= passthrough_ok;
      in_req.platform_id_present <= platform_id_present;
      in_req.platform_id_ack     <= platform_id_ack;
      in_req.platform_key_ack    <= platform_key_ack;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign request_valid       = out_res.request_valid;
  assign request_kind        = out_res.request_kind;
  assign send_flag_clear     = out_res.send_flag_clear;
  assign passthrough_start   = out_res.passthrough_start;
  assign platform_id_release = out_res.platform_id_release;
  assign ack_valid           = out_res.ack_valid;
  assign ack_value           = out_res.ack_value;
  assign failure_valid       = out_res.failure_valid;
  assign failure_step        = out_res.failure_step;
  assign phase_now           = out_res.phase_now;

endmodule
